// File: hw/rtl/plis_pkg.sv
// Shared types and constants for the packed list block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package plis_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int DATA_W           = 32;
  localparam int COUNT_OUT_W      = 5;

  // Request operation codes
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                   found;
    status_t                status;
    logic [COUNT_OUT_W-1:0] count_after;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    issue;
    logic    shift_wr;
    logic    ins_wr;
    logic    dec;
    logic    set_res;
    logic    res_found;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    func_t func;
    logic  full;
    logic  rp_lt_count;
    logic  rd_vld;
    logic  hit;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/plis_ctrl.sv
// Controller state machine for the packed list block.
// Depends on plis_pkg; drives commands into plis_datapath.
`timescale 1ns / 1ps
`default_nettype none

module plis_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire plis_pkg::dp_stat_t stat,
  output plis_pkg::cmd_t         cmd
);

  plis_pkg::state_t state;
  plis_pkg::state_t state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plis_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decide next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      plis_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = plis_pkg::S_EXEC;
        end
      end
      plis_pkg::S_EXEC: begin
        case (stat.func)
          plis_pkg::FUNC_INSERT: begin
            cmd.set_res = 1'b1;
            if (stat.full) begin
              cmd.res_status = plis_pkg::ST_FULL;
            end else begin
              cmd.ins_wr     = 1'b1;
              cmd.res_status = plis_pkg::ST_OK;
            end
            state_next = plis_pkg::S_FINISH;
          end
          plis_pkg::FUNC_DELETE, plis_pkg::FUNC_SEARCH: begin
            state_next = plis_pkg::S_SCAN;
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = plis_pkg::ST_OK;
            state_next     = plis_pkg::S_FINISH;
          end
        endcase
      end
      plis_pkg::S_SCAN: begin
        // Stream reads and compare the entry that arrives
        cmd.issue = stat.rp_lt_count;
        if (stat.hit) begin
          if (stat.func == plis_pkg::FUNC_DELETE) begin
            state_next = plis_pkg::S_SHIFT;
          end else begin
            cmd.set_res    = 1'b1;
            cmd.res_found  = 1'b1;
            cmd.res_status = plis_pkg::ST_OK;
            state_next     = plis_pkg::S_FINISH;
          end
        end else if (!stat.rd_vld && !stat.rp_lt_count) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = plis_pkg::ST_NOT_FOUND;
          state_next     = plis_pkg::S_FINISH;
        end
      end
      plis_pkg::S_SHIFT: begin
        // Move each later entry down by one place
        cmd.issue    = stat.rp_lt_count;
        cmd.shift_wr = stat.rd_vld;
        if (!stat.rd_vld && !stat.rp_lt_count) begin
          cmd.dec        = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_found  = 1'b1;
          cmd.res_status = plis_pkg::ST_OK;
          state_next     = plis_pkg::S_FINISH;
        end
      end
      plis_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = plis_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plis_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/plis_datapath.sv
// Datapath for the packed list block: entry memory, count, scan pointer,
// result and output registers. Depends on plis_pkg; driven by plis_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module plis_datapath #(
  parameter int CAPACITY = plis_pkg::DEFAULT_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire plis_pkg::req_t     req,
  input  wire plis_pkg::cmd_t     cmd,
  output plis_pkg::dp_stat_t      stat,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output plis_pkg::rsp_t          rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [plis_pkg::DATA_W-1:0] mem [CAPACITY];

  logic [plis_pkg::DATA_W-1:0] key;
  plis_pkg::func_t             func;
  logic [CW-1:0]               count;
  logic [CW-1:0]               rp;
  logic [CW-1:0]               rd_idx;
  logic [plis_pkg::DATA_W-1:0] rdata;
  logic                        rd_vld;
  logic                        res_found;
  plis_pkg::status_t           res_status;

  logic [CW-1:0]                    shift_idx;
  logic [CW+plis_pkg::COUNT_OUT_W-1:0] count_ext;

  assign shift_idx = rd_idx - 1'b1;
  assign count_ext = {{plis_pkg::COUNT_OUT_W{1'b0}}, count};

  // Status back to the controller
  assign stat.func        = func;
  assign stat.full        = (count >= CW'(CAPACITY));
  assign stat.rp_lt_count = (rp < count);
  assign stat.rd_vld      = rd_vld;
  assign stat.hit         = rd_vld && (rdata == key);
  assign stat.out_free    = !rsp_valid || rsp_ready;

  // Latch the request payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= req.value;
      func <= req.func;
    end
  end

  // Write entries: append, or shift one place down
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      mem[count[IW-1:0]] <= key;
    end else if (cmd.shift_wr) begin
      mem[shift_idx[IW-1:0]] <= rdata;
    end
  end

  // Registered read port with the index of the data it holds
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rdata  <= mem[rp[IW-1:0]];
      rd_idx <= rp;
    end
  end

  // Advance the read pointer and track read data validity
  always_ff @(posedge clk) begin
    if (rst) begin
      rp     <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.load) begin
        rp <= '0;
      end else if (cmd.issue) begin
        rp <= rp + 1'b1;
      end
    end
  end

  // Update the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_wr) begin
      count <= count + 1'b1;
    end else if (cmd.dec) begin
      count <= count - 1'b1;
    end
  end

  // Hold the result of the current item
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_found  <= cmd.res_found;
      res_status <= cmd.res_status;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.found       <= res_found;
      rsp.status      <= res_status;
      rsp.count_after <= count_ext[plis_pkg::COUNT_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/packed_list_insert_delete_search.sv
// Packed unsorted list with insert, delete-first-match and search.
//
// Requests arrive on req_valid/req_ready with a req_t payload (func, value);
// one response per request leaves on rsp_valid/rsp_ready as an rsp_t
// (found, status, count_after). Insert appends at the end, or reports
// ST_FULL and leaves the list alone when CAPACITY entries are held. Delete
// removes the first equal entry and closes the gap; search only reports.
// Function code 3 does nothing and returns the current count.
//
// One item is worked at a time. Insert and no-op go from S_EXEC straight
// to S_FINISH. Search and delete read entries in S_SCAN until one matches
// or all have been read; a delete that hits then moves the later entries
// down in S_SHIFT. The single memory read port streams one entry per
// cycle, first for the compare and then for the shift. S_FINISH loads the
// response into the output register; a new item is accepted the cycle
// after the previous response is loaded there.
// Reset empties the list (count zero) and clears the response valid.
// A stalled receiver holds the response in the output register; the next
// item may already be accepted and will wait to finish until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module packed_list_insert_delete_search #(
  parameter int CAPACITY = plis_pkg::DEFAULT_CAPACITY
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire plis_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output plis_pkg::rsp_t      rsp
);

  plis_pkg::cmd_t     cmd;
  plis_pkg::dp_stat_t stat;

  // Sequence each item
  plis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store entries and build responses
  plis_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: hw/rtl/plis_checker.sv
// Port-level checks for the packed list block, bound to its top level.
// Depends on plis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plis_checker #(
  parameter int CAPACITY = plis_pkg::DEFAULT_CAPACITY
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire plis_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire plis_pkg::rsp_t rsp
);

  // Reset drops the response valid
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // A hit always reports ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == plis_pkg::ST_OK)
    else $error("found with non-ok status");

  // A refused insert only happens on a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == plis_pkg::ST_FULL |->
      rsp.count_after == plis_pkg::COUNT_OUT_W'(CAPACITY) && !rsp.found)
    else $error("full status with wrong count");

  // Hold an offered request until it is taken
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("offered request dropped or changed");

endmodule

bind packed_list_insert_delete_search plis_checker #(
  .CAPACITY (CAPACITY)
) u_plis_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
